### rtl/core/ppm_capture_decoder_defines.svh
// ---------------------------------------------------------------------------
// ppm_capture_decoder_defines: assertion macros
// Shared concurrent assertion wrappers for the decoder checkers.
// ---------------------------------------------------------------------------
`ifndef PPM_CAPTURE_DECODER_DEFINES_SVH
`define PPM_CAPTURE_DECODER_DEFINES_SVH

// Assertion sampled on clk, switched off while rst is high
`define PPM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion sampled on clk, also checked through reset
`define PPM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/ppm_pkg.sv
// ---------------------------------------------------------------------------
// ppm_pkg: PPM capture decoder package
// Payload types and fixed decode constants.
// ---------------------------------------------------------------------------
package ppm_pkg;

  // Field widths
  localparam int unsigned CAPTURE_W = 16;
  localparam int unsigned WIDTH_W   = 15;
  localparam int unsigned INDEX_W   = 4;
  localparam int unsigned VALUE_W   = 13;
  localparam int unsigned GAIN_W    = 7;
  localparam int unsigned POS_W     = 5;

  typedef logic        [CAPTURE_W-1:0] capture_t;
  typedef logic        [WIDTH_W-1:0]   pulse_width_t;
  typedef logic        [INDEX_W-1:0]   chan_index_t;
  typedef logic signed [VALUE_W-1:0]   chan_value_t;
  typedef logic signed [GAIN_W-1:0]    gain_t;
  typedef logic        [POS_W-1:0]     frame_pos_t;

  // Pulse windows in microseconds (bounds are exclusive)
  localparam pulse_width_t SYNC_MIN_US = 15'd4000;
  localparam pulse_width_t SYNC_MAX_US = 15'd19000;
  localparam pulse_width_t CHAN_MIN_US = 15'd800;
  localparam pulse_width_t CHAN_MAX_US = 15'd2200;

  // Channel centering; centered value fits 12 bits signed
  localparam int unsigned CENTER_W      = 12;
  localparam logic [CENTER_W-1:0] CHAN_CENTER_US = 12'd1500;

  // Gain trim limits and base
  localparam gain_t GAIN_LOW  = -7'sd10;
  localparam gain_t GAIN_HIGH = 7'sd40;
  localparam gain_t GAIN_BASE = 7'sd10;
  localparam int unsigned SCALE_W = 6;

  // Product (width-1500)*(gain+10): |p| <= 34950
  localparam int unsigned PROD_W = 17;
  localparam int unsigned MAG_W  = 16;

  // Divide by ten: q = (m * 52429) >> 19, exact for m < 2^16
  localparam int unsigned RECIP_W     = 17;
  localparam logic [RECIP_W-1:0] RECIP_10 = 17'd52429;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned QUOT_W      = 12;

  // Frame position codes
  localparam frame_pos_t POS_UNSYNC = 5'd0;
  localparam frame_pos_t POS_FIRST  = 5'd1;

endpackage

### rtl/core/ppm_in_if.sv
// ---------------------------------------------------------------------------
// ppm_in_if: capture timestamp channel
// Valid/ready channel carrying one edge capture timestamp per word.
// ---------------------------------------------------------------------------
interface ppm_in_if;
  import ppm_pkg::*;

  logic     valid;
  logic     ready;
  capture_t capture_time;

  modport source (output valid, output capture_time, input ready);
  modport sink   (input valid, input capture_time, output ready);
endinterface

### rtl/core/ppm_out_if.sv
// ---------------------------------------------------------------------------
// ppm_out_if: decoded pulse result channel
// Valid/ready channel carrying one decode result word per edge.
// ---------------------------------------------------------------------------
interface ppm_out_if;
  import ppm_pkg::*;

  logic        valid;
  logic        ready;
  logic        channel_write;
  chan_index_t channel_index;
  chan_value_t channel_value;
  logic        sync_seen;
  logic        sync_lost;

  modport source (
    output valid, output channel_write, output channel_index,
    output channel_value, output sync_seen, output sync_lost,
    input  ready
  );
  modport sink (
    input  valid, input channel_write, input channel_index,
    input  channel_value, input sync_seen, input sync_lost,
    output ready
  );
endinterface

### rtl/core/ppm_capture_decoder.sv
// ---------------------------------------------------------------------------
// ppm_capture_decoder: RC PPM frame decoder
// Turns edge capture timestamps into sync events and scaled channel values.
// ---------------------------------------------------------------------------
//  port      | dir | word
//  ----------+-----+---------------------------------------------------------
//  capture   | in  | capture_time, 16-bit timer value at the edge
//  result    | out | channel_write, channel_index, channel_value, sync flags
//  cfg_write | in  | cfg_data loads gain_adjust (7-bit signed)
//
//  One word in and one word out per cycle when not stalled.
//  The input register loads at the accepting edge; decode and scale multiply
//  fill the middle stage, and the divide-by-ten reciprocal multiply fills the
//  result register, whose valid bit drives result.valid.
//  Synchronous reset clears the stage valids, the last timestamp, the frame
//  position and the gain. A stalled result holds; the earlier stages keep
//  filling until the pipe is full, then capture.ready drops.
// ---------------------------------------------------------------------------
module ppm_capture_decoder #(
  parameter int MAX_CHANNELS = 16
) (
  input  logic           clk,
  input  logic           rst,
  ppm_in_if.sink         capture,
  ppm_out_if.source      result,
  input  logic           cfg_write,
  input  ppm_pkg::gain_t cfg_data
);
  import ppm_pkg::*;

  localparam frame_pos_t POS_LAST = POS_W'(MAX_CHANNELS);

  // Stage valids and advance enables
  logic v0, v1, v2;
  logic en0, en1, en2;

  assign en2 = !v2 || result.ready;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;
  assign capture.ready = en0;

  // Configuration register
  gain_t gain_adjust;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_adjust <= '0;
    end else if (cfg_write) begin
      gain_adjust <= cfg_data;
    end
  end

  // Stage 0: input register
  capture_t cap0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en0) begin
      v0 <= capture.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && capture.valid) begin
      cap0 <= capture.capture_time;
    end
  end

  // Stage 1: pulse width, classification, frame state, scale multiply
  capture_t     previous_capture;
  frame_pos_t   frame_position;
  frame_pos_t   frame_position_next;
  capture_t     delta;
  pulse_width_t width;
  logic         is_sync, is_chan, armed;
  logic         wr1_next, seen1_next, lost1_next;
  gain_t        gain_sat, scale7;
  logic signed [CENTER_W-1:0]         centered;
  logic signed [CENTER_W+GAIN_W-1:0]  prod_full;
  logic signed [PROD_W-1:0]           prod1_next;

  always_comb begin
    delta    = cap0 - previous_capture;
    width    = delta[CAPTURE_W-1:1];
    is_sync  = (width > SYNC_MIN_US) && (width < SYNC_MAX_US);
    is_chan  = (width > CHAN_MIN_US) && (width < CHAN_MAX_US);
    armed    = (frame_position >= POS_FIRST) && (frame_position <= POS_LAST);

    wr1_next   = 1'b0;
    seen1_next = 1'b0;
    lost1_next = 1'b0;
    frame_position_next = frame_position;
    if (is_sync) begin
      seen1_next = 1'b1;
      frame_position_next = POS_FIRST;
    end else if (armed) begin
      if (is_chan) begin
        wr1_next = 1'b1;
        frame_position_next = frame_position + POS_FIRST;
      end else begin
        lost1_next = 1'b1;
        frame_position_next = POS_UNSYNC;
      end
    end

    // Saturate trim, then scale = gain + 10 (0..50)
    if (gain_adjust < GAIN_LOW) begin
      gain_sat = GAIN_LOW;
    end else if (gain_adjust > GAIN_HIGH) begin
      gain_sat = GAIN_HIGH;
    end else begin
      gain_sat = gain_adjust;
    end
    scale7 = gain_sat + GAIN_BASE;

    centered  = $signed(width[CENTER_W-1:0] - CHAN_CENTER_US);
    prod_full = centered * $signed({1'b0, scale7[SCALE_W-1:0]});
    prod1_next = wr1_next ? prod_full[PROD_W-1:0] : '0;
  end

  logic                     wr1, seen1, lost1;
  chan_index_t              idx1;
  logic signed [PROD_W-1:0] prod1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1               <= 1'b0;
      previous_capture <= '0;
      frame_position   <= POS_UNSYNC;
    end else if (en1) begin
      v1 <= v0;
      if (v0) begin
        previous_capture <= cap0;
        frame_position   <= frame_position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && v0) begin
      wr1   <= wr1_next;
      seen1 <= seen1_next;
      lost1 <= lost1_next;
      idx1  <= wr1_next ? INDEX_W'(frame_position - POS_FIRST) : '0;
      prod1 <= prod1_next;
    end
  end

  // Stage 2: divide by ten, truncating toward zero
  logic [PROD_W-1:0]          mag_full;
  logic [MAG_W-1:0]           mag;
  logic [MAG_W+RECIP_W-1:0]   quot_full;
  logic [QUOT_W-1:0]          quot;
  chan_value_t                value2_next;

  always_comb begin
    mag_full  = prod1[PROD_W-1] ? PROD_W'(-prod1) : PROD_W'(prod1);
    mag       = mag_full[MAG_W-1:0];
    quot_full = mag * RECIP_10;
    quot      = quot_full[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
    value2_next = prod1[PROD_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      result.channel_write <= wr1;
      result.channel_index <= idx1;
      result.channel_value <= value2_next;
      result.sync_seen     <= seen1;
      result.sync_lost     <= lost1;
    end
  end

  assign result.valid = v2;

endmodule

### rtl/core/ppm_capture_decoder_checker.sv
// ---------------------------------------------------------------------------
// ppm_capture_decoder_checker: port-level checks
// Concurrent assertions on the decoder's result channel, bound to the top.
// ---------------------------------------------------------------------------
`include "ppm_capture_decoder_defines.svh"

module ppm_capture_decoder_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic                channel_write,
  input ppm_pkg::chan_index_t channel_index,
  input ppm_pkg::chan_value_t channel_value,
  input logic                sync_seen,
  input logic                sync_lost
);
  import ppm_pkg::*;

  // Stalled result word must hold
  `PPM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(channel_write) && $stable(channel_index) && $stable(channel_value) && $stable(sync_seen) && $stable(sync_lost), "result word changed while stalled")

  // At most one event per edge
  `PPM_ASSERT(a_one_event, out_valid |-> $onehot0({channel_write, sync_seen, sync_lost}), "more than one event flag set")

  // No channel: index and value are zero
  `PPM_ASSERT(a_idle_zero, out_valid && !channel_write |-> channel_index == '0 && channel_value == '0, "index or value nonzero without channel write")

  // Scaled value stays within the saturated gain range
  `PPM_ASSERT(a_value_range, out_valid |-> (channel_value >= -13'sd3495) && (channel_value <= 13'sd3495), "channel value out of range")

  // Nothing comes out right after reset
  `PPM_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

endmodule

bind ppm_capture_decoder ppm_capture_decoder_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .channel_write (result.channel_write),
  .channel_index (result.channel_index),
  .channel_value (result.channel_value),
  .sync_seen     (result.sync_seen),
  .sync_lost     (result.sync_lost)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: PPM capture decoder testbench
// Feeds edge timestamps built from chosen pulse widths, predicts every
// result word from a local model of the decoder and checks it field by field.
// ---------------------------------------------------------------------------
module tb;
  import ppm_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_PCT     = 11;
  localparam int NUM_CHANNELS = 16;
  localparam int PHASES       = 6;
  localparam int PHASE_EDGES  = 320;

  typedef struct {
    logic        channel_write;
    chan_index_t channel_index;
    chan_value_t channel_value;
    logic        sync_seen;
    logic        sync_lost;
  } decode_word_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  cfg_write;
  gain_t cfg_data;

  ppm_in_if  capture ();
  ppm_out_if result ();

  ppm_capture_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .capture   (capture),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  // Decoder model state
  capture_t   last_stamp;
  frame_pos_t frame_pos;
  gain_t      gain_trim;

  // Timestamps waiting to go out, decode words waiting to come back
  capture_t     edge_q[$];
  decode_word_t decoded_q[$];

  capture_t stamp_cursor;
  logic     steady;
  int       errors = 0;
  int       stall_cycles = 0;

  always #1 clk = ~clk;

  // Model: one edge in, one decode word out
  function automatic decode_word_t decode_edge(capture_t stamp);
    decode_word_t w;
    capture_t     diff;
    int           width;
    int           g;
    w.channel_write = 1'b0;
    w.channel_index = '0;
    w.channel_value = '0;
    w.sync_seen     = 1'b0;
    w.sync_lost     = 1'b0;
    diff       = stamp - last_stamp;
    width      = int'(diff >> 1);
    last_stamp = stamp;
    if (width > int'(SYNC_MIN_US) && width < int'(SYNC_MAX_US)) begin
      frame_pos   = POS_FIRST;
      w.sync_seen = 1'b1;
    end else if (frame_pos >= POS_FIRST && frame_pos <= frame_pos_t'(NUM_CHANNELS)) begin
      if (width > int'(CHAN_MIN_US) && width < int'(CHAN_MAX_US)) begin
        // gain is clamped to its legal range before scaling
        g = int'(gain_trim);
        if (g < int'(GAIN_LOW)) g = int'(GAIN_LOW);
        if (g > int'(GAIN_HIGH)) g = int'(GAIN_HIGH);
        w.channel_write = 1'b1;
        w.channel_index = chan_index_t'(frame_pos - POS_FIRST);
        w.channel_value = chan_value_t'((width - int'(CHAN_CENTER_US)) *
                                        (g + int'(GAIN_BASE)) / int'(GAIN_BASE));
        frame_pos = frame_pos + 5'd1;
      end else begin
        frame_pos   = POS_UNSYNC;
        w.sync_lost = 1'b1;
      end
    end
    return w;
  endfunction

  // Next timestamp for a pulse of the given width (us); low tick bit random
  task automatic push_width(int width_us);
    stamp_cursor = stamp_cursor + capture_t'(2 * width_us + $urandom_range(1));
    edge_q.push_back(stamp_cursor);
  endtask

  function automatic int chan_width();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) return int'(CHAN_MIN_US) + 1;
    if (pick < 10) return int'(CHAN_MAX_US) - 1;
    if (pick < 14) return int'(CHAN_CENTER_US);
    return $urandom_range(int'(CHAN_MAX_US) - 1, int'(CHAN_MIN_US) + 1);
  endfunction

  // Mostly sync + channel frames, some longer than a full frame, some noise
  task automatic queue_random_edges(int count);
    int pushed;
    int n_chan;
    pushed = 0;
    while (pushed < count) begin
      if ($urandom_range(99) < 85) begin
        push_width($urandom_range(int'(SYNC_MAX_US) - 1, int'(SYNC_MIN_US) + 1));
        pushed++;
        n_chan = ($urandom_range(3) == 0) ? $urandom_range(NUM_CHANNELS + 2, NUM_CHANNELS - 2)
                                          : $urandom_range(NUM_CHANNELS, 1);
        repeat (n_chan) begin
          push_width(chan_width());
          pushed++;
        end
      end else begin
        case ($urandom_range(3))
          0: begin
            stamp_cursor = capture_t'($urandom);
            edge_q.push_back(stamp_cursor);
          end
          1: push_width($urandom_range(int'(CHAN_MIN_US), 0));
          2: push_width($urandom_range(int'(SYNC_MIN_US), int'(CHAN_MAX_US)));
          default: push_width($urandom_range(32767, int'(SYNC_MAX_US)));
        endcase
        pushed++;
      end
    end
  endtask

  // Wait until every queued word is accepted and every result is back
  task automatic drain();
    do @(negedge clk);
    while (edge_q.size() != 0 || capture.valid || decoded_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(gain_t g);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= g;
    gain_trim  = g;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Driver: one capture word per handshake
  always @(posedge clk) begin
    if (rst) begin
      capture.valid <= 1'b0;
    end else begin
      if (capture.valid && capture.ready)
        decoded_q.push_back(decode_edge(capture.capture_time));
      if (!capture.valid || capture.ready) begin
        if (edge_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          capture.valid        <= 1'b1;
          capture.capture_time <= edge_q.pop_front();
        end else begin
          capture.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin
    decode_word_t exp_w;
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        if (decoded_q.size() == 0) begin
          $error("result word with no prediction pending");
          errors++;
        end else begin
          exp_w = decoded_q.pop_front();
          if (result.channel_write !== exp_w.channel_write) begin
            $error("channel_write: expected %0d, got %0d",
                   exp_w.channel_write, result.channel_write);
            errors++;
          end
          if (result.channel_index !== exp_w.channel_index) begin
            $error("channel_index: expected %0d, got %0d",
                   exp_w.channel_index, result.channel_index);
            errors++;
          end
          if (result.channel_value !== exp_w.channel_value) begin
            $error("channel_value: expected %0d, got %0d",
                   exp_w.channel_value, result.channel_value);
            errors++;
          end
          if (result.sync_seen !== exp_w.sync_seen) begin
            $error("sync_seen: expected %0d, got %0d", exp_w.sync_seen, result.sync_seen);
            errors++;
          end
          if (result.sync_lost !== exp_w.sync_lost) begin
            $error("sync_lost: expected %0d, got %0d", exp_w.sync_lost, result.sync_lost);
            errors++;
          end
        end
      end
      result.ready <= steady || $urandom_range(99) >= IDLE_PCT;
    end
  end

  // Watchdog: no handshake on either side for too long
  always @(posedge clk) begin
    if (rst || (capture.valid && capture.ready) || (result.valid && result.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus sequence
  initial begin
    gain_t phase_gain [PHASES];
    phase_gain = '{7'sd40, -7'sd10, -7'sd64, 7'sd63, 7'sd0, 7'sd0};
    phase_gain[4] = gain_t'($urandom_range(int'(GAIN_HIGH) + 10, 0) - 10);
    phase_gain[5] = gain_t'($urandom_range(127));
    capture.valid        = 1'b0;
    capture.capture_time = '0;
    result.ready         = 1'b0;
    cfg_write            = 1'b0;
    cfg_data             = '0;
    steady               = 1'b0;
    last_stamp           = '0;
    frame_pos            = POS_UNSYNC;
    gain_trim            = '0;
    stamp_cursor         = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: window bounds, sync loss, unsynced pulses, full frame
    push_width(int'(SYNC_MIN_US) + 1);   // first edge, measured from zero
    push_width(int'(CHAN_MIN_US));       // too short while armed: loses sync
    push_width(int'(SYNC_MIN_US));       // just below sync, unsynced: ignored
    push_width(int'(SYNC_MAX_US));       // just above sync: ignored
    push_width(32767);                   // widest pulse
    push_width(0);                       // back-to-back edges
    push_width(int'(SYNC_MAX_US) - 1);
    push_width(int'(CHAN_MIN_US) + 1);
    push_width(int'(CHAN_MAX_US) - 1);
    push_width(int'(CHAN_CENTER_US));
    repeat (NUM_CHANNELS - 3) push_width(chan_width());
    push_width(int'(CHAN_MAX_US));       // frame full: ignored, no loss
    push_width(int'(CHAN_MAX_US) - 1);   // frame full: no value
    push_width(5000);
    push_width(int'(CHAN_MAX_US));       // too long while armed: loses sync
    drain();

    // Random phases, one gain setting each
    for (int p = 0; p < PHASES; p++) begin
      write_gain(phase_gain[p]);
      steady = (p == 2);
      queue_random_edges(PHASE_EDGES);
      drain();
    end

    if (errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
